// ===== hw/rtl/fvam_pkg.sv =====
// ----------------------------------------------------------------------------
// fvam_pkg: shared types and constants for the flow vector polar unit
// Payload structs, pipeline work structs, fixed widths and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package fvam_pkg;

	// field widths
	localparam int COORD_BITS = 16;
	localparam int ANGLE_BITS = 16;
	localparam int MAG_BITS   = 17;
	localparam int DIFF_W     = COORD_BITS + 1;

	// CORDIC datapath: coordinates scaled by 2^PRESCALE plus growth headroom
	localparam int PRESCALE  = 24;
	localparam int CW        = DIFF_W + PRESCALE + 3;
	localparam int ZW        = 25;
	localparam int TABLE_LEN = 24;

	// square root: one result bit per stage
	localparam int SQRT_STEPS = MAG_BITS;
	localparam int N_W        = 2 * SQRT_STEPS;
	localparam int REM_W      = MAG_BITS + 3;

	// angle units of 2^-15 degree
	localparam logic signed [ZW-1:0] FULL_TURN = 25'sd11796480;
	localparam logic signed [ZW-1:0] HALF_TURN = 25'sd5898240;
	localparam logic [ANGLE_BITS-1:0] ANGLE_WRAP = 16'd46080;
	localparam logic [ZW-1:0] ANGLE_ROUND = 25'd128;

	// atan(2^-i) in units of 2^-15 degree, rounded
	localparam logic [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
		25'd1474560, 25'd870484, 25'd459940, 25'd233473,
		25'd117189,  25'd58652,  25'd29333,  25'd14667,
		25'd7334,    25'd3667,   25'd1833,   25'd917,
		25'd458,     25'd229,    25'd115,    25'd57,
		25'd29,      25'd14,     25'd7,      25'd4,
		25'd2,       25'd1,      25'd0,      25'd0
	};

	typedef struct packed {
		logic [COORD_BITS-1:0] src_x;
		logic [COORD_BITS-1:0] src_y;
		logic [COORD_BITS-1:0] dst_x;
		logic [COORD_BITS-1:0] dst_y;
	} pair_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] angle;
		logic [MAG_BITS-1:0]   magnitude;
	} result_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cord_t;

	typedef struct packed {
		logic [N_W-1:0]      n;
		logic [REM_W-1:0]    rem;
		logic [MAG_BITS-1:0] root;
	} sqrt_t;

endpackage

// ===== hw/rtl/flow_vector_angle_magnitude.sv =====
// ----------------------------------------------------------------------------
// flow_vector_angle_magnitude: polar form of a tracked point's motion vector
// Pipelined CORDIC vectoring and digit-by-digit square root.
// ----------------------------------------------------------------------------
// Usage:
//   Drive pair (source and destination, unsigned Q12.4) and pulse start. A
//   pair transfers at every clock edge with start high and busy low; busy is
//   always low, so a new pair may transfer in every cycle.
//   The result (angle in 1/128 degree, magnitude in Q13.4) appears on result
//   for exactly one cycle with done high, and transfers at the edge that ends
//   that cycle. The receiver cannot stall, so nothing is held back.
// Pipeline: the start edge loads the first of three front stages, then one
//   stage per root bit (17) or CORDIC micro-rotation, whichever is more, then
//   one output stage.
// Throughput: one pair per cycle, every stage is a plain register stage.
// Reset: arst_n clears all valid bits; pairs in flight are dropped and done
//   stays low until a new pair comes through.
// ----------------------------------------------------------------------------
module flow_vector_angle_magnitude #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  fvam_pkg::pair_t    pair,
	output logic               done,
	output fvam_pkg::result_t  result
);

	localparam int SQ_STEPS = fvam_pkg::SQRT_STEPS;
	localparam int DEPTH    = (CORDIC_STEPS > SQ_STEPS) ? CORDIC_STEPS : SQ_STEPS;

	logic              vld_s3, zero_s3;
	fvam_pkg::cord_t   cord_s3;
	fvam_pkg::sqrt_t   sq_s3;

	// step stages, element k is the register after step k
	logic              vld_sn  [DEPTH];
	logic              zero_sn [DEPTH];
	fvam_pkg::cord_t   cord_sn [DEPTH];
	fvam_pkg::sqrt_t   sq_sn   [DEPTH];

	fvam_pkg::result_t res_d;
	fvam_pkg::result_t result_q;
	logic              done_q;

	assign busy = 1'b0;

	fvam_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.pair    (pair),
		.vld_s3  (vld_s3),
		.zero_s3 (zero_s3),
		.cord_s3 (cord_s3),
		.sq_s3   (sq_s3)
	);

	// rotation and root pipeline
	generate
		for (genvar k = 0; k < DEPTH; k++) begin : g_step
			logic            v_in, z_in;
			fvam_pkg::cord_t c_in, c_nx;
			fvam_pkg::sqrt_t s_in, s_nx;

			if (k == 0) begin : g_first
				assign v_in = vld_s3;
				assign z_in = zero_s3;
				assign c_in = cord_s3;
				assign s_in = sq_s3;
			end else begin : g_next
				assign v_in = vld_sn[k-1];
				assign z_in = zero_sn[k-1];
				assign c_in = cord_sn[k-1];
				assign s_in = sq_sn[k-1];
			end

			fvam_cordic_step #(
				.IDX    (k),
				.ACTIVE ((k < CORDIC_STEPS) && (k < fvam_pkg::TABLE_LEN))
			) u_cordic (
				.c_in  (c_in),
				.c_out (c_nx)
			);

			fvam_sqrt_step #(
				.IDX (k)
			) u_sqrt (
				.s_in  (s_in),
				.s_out (s_nx)
			);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_sn[k] <= 1'b0;
				end else begin
					vld_sn[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				zero_sn[k] <= z_in;
				cord_sn[k] <= c_nx;
				sq_sn[k]   <= s_nx;
			end
		end
	endgenerate

	fvam_back u_back (
		.zero (zero_sn[DEPTH-1]),
		.c_in (cord_sn[DEPTH-1]),
		.s_in (sq_sn[DEPTH-1]),
		.res  (res_d)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_sn[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hw/rtl/fvam_front.sv =====
// ----------------------------------------------------------------------------
// fvam_front: first three pipeline stages
// Differences, squares and CORDIC setup, sum of squares.
// ----------------------------------------------------------------------------
module fvam_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  fvam_pkg::pair_t    pair,
	output logic               vld_s3,
	output logic               zero_s3,
	output fvam_pkg::cord_t    cord_s3,
	output fvam_pkg::sqrt_t    sq_s3
);

	localparam int CB = fvam_pkg::COORD_BITS;
	localparam int DW = fvam_pkg::DIFF_W;
	localparam int CW = fvam_pkg::CW;
	localparam int PS = fvam_pkg::PRESCALE;

	logic                 vld_s1, vld_s2;
	logic                 zero_s1, zero_s2;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic [2*CB-1:0]      sqx_s2, sqy_s2;
	fvam_pkg::cord_t      cord_s2;

	logic [CB-1:0]        ax, ay;
	logic signed [CW-1:0] dx_ext, dy_ext;
	fvam_pkg::cord_t      cord_init;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: displacement
	always_ff @(posedge clk) begin
		dx_s1   <= $signed({1'b0, pair.dst_x[CB-1:0]}) - $signed({1'b0, pair.src_x[CB-1:0]});
		dy_s1   <= $signed({1'b0, pair.dst_y[CB-1:0]}) - $signed({1'b0, pair.src_y[CB-1:0]});
		zero_s1 <= (pair.dst_x[CB-1:0] == pair.src_x[CB-1:0]) &&
			(pair.dst_y[CB-1:0] == pair.src_y[CB-1:0]);
	end

	// stage 2 logic: absolute values, CORDIC start vector in the right half plane
	always_comb begin
		ax     = dx_s1[DW-1] ? CB'(-dx_s1) : CB'(dx_s1);
		ay     = dy_s1[DW-1] ? CB'(-dy_s1) : CB'(dy_s1);
		dx_ext = CW'(dx_s1);
		dy_ext = CW'(dy_s1);
		cord_init.x = CW'({1'b0, ax}) <<< PS;
		// vector is (dx, -dy); turned by 180 degrees when dx is negative
		cord_init.y = (dx_s1[DW-1] ? dy_ext : -dy_ext) <<< PS;
		cord_init.z = dx_s1[DW-1] ? fvam_pkg::HALF_TURN : '0;
	end

	always_ff @(posedge clk) begin
		sqx_s2  <= ax * ax;
		sqy_s2  <= ay * ay;
		cord_s2 <= cord_init;
		zero_s2 <= zero_s1;
	end

	// stage 3: sum of squares
	always_ff @(posedge clk) begin
		sq_s3.n    <= fvam_pkg::N_W'(sqx_s2) + fvam_pkg::N_W'(sqy_s2);
		sq_s3.rem  <= '0;
		sq_s3.root <= '0;
		cord_s3    <= cord_s2;
		zero_s3    <= zero_s2;
	end

endmodule

// ===== hw/rtl/fvam_cordic_step.sv =====
// ----------------------------------------------------------------------------
// fvam_cordic_step: one CORDIC vectoring micro-rotation
// Rotates toward the x axis by atan(2^-IDX); passes through when inactive.
// ----------------------------------------------------------------------------
module fvam_cordic_step #(
	parameter int IDX    = 0,
	parameter bit ACTIVE = 1'b1
) (
	input  fvam_pkg::cord_t c_in,
	output fvam_pkg::cord_t c_out
);

	localparam int CW = fvam_pkg::CW;
	localparam int ZW = fvam_pkg::ZW;

	generate
		if (ACTIVE) begin : g_rot
			logic signed [CW-1:0] xi, yi, xs, ys;
			logic signed [ZW-1:0] zi, t;

			always_comb begin
				xi = c_in.x;
				yi = c_in.y;
				zi = c_in.z;
				// arithmetic shift floors, as required
				xs = xi >>> IDX;
				ys = yi >>> IDX;
				t  = $signed(fvam_pkg::ATAN_TABLE[IDX]);
				if (!yi[CW-1]) begin
					c_out.x = xi + ys;
					c_out.y = yi - xs;
					c_out.z = zi + t;
				end else begin
					c_out.x = xi - ys;
					c_out.y = yi + xs;
					c_out.z = zi - t;
				end
			end
		end else begin : g_pass
			assign c_out = c_in;
		end
	endgenerate

endmodule

// ===== hw/rtl/fvam_sqrt_step.sv =====
// ----------------------------------------------------------------------------
// fvam_sqrt_step: one digit of the restoring integer square root
// Brings down two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module fvam_sqrt_step #(
	parameter int IDX = 0
) (
	input  fvam_pkg::sqrt_t s_in,
	output fvam_pkg::sqrt_t s_out
);

	localparam int RW = fvam_pkg::REM_W;
	localparam int MB = fvam_pkg::MAG_BITS;
	localparam int NW = fvam_pkg::N_W;

	generate
		if (IDX < fvam_pkg::SQRT_STEPS) begin : g_digit
			logic [RW-1:0] rem_sh, trial;

			always_comb begin
				rem_sh = {s_in.rem[RW-3:0], s_in.n[NW-1-2*IDX -: 2]};
				trial  = RW'({s_in.root, 2'b01});
				s_out.n = s_in.n;
				if (rem_sh >= trial) begin
					s_out.rem  = rem_sh - trial;
					s_out.root = {s_in.root[MB-2:0], 1'b1};
				end else begin
					s_out.rem  = rem_sh;
					s_out.root = {s_in.root[MB-2:0], 1'b0};
				end
			end
		end else begin : g_pass
			assign s_out = s_in;
		end
	endgenerate

endmodule

// ===== hw/rtl/fvam_back.sv =====
// ----------------------------------------------------------------------------
// fvam_back: result formatting
// Wraps and rounds the angle, rounds the root, forces the zero vector case.
// ----------------------------------------------------------------------------
module fvam_back (
	input  logic               zero,
	input  fvam_pkg::cord_t    c_in,
	input  fvam_pkg::sqrt_t    s_in,
	output fvam_pkg::result_t  res
);

	localparam int ZW = fvam_pkg::ZW;
	localparam int AB = fvam_pkg::ANGLE_BITS;
	localparam int MB = fvam_pkg::MAG_BITS;
	localparam int RW = fvam_pkg::REM_W;

	logic signed [ZW-1:0] zw;
	logic [ZW-1:0]        zr;
	logic [AB-1:0]        ang;
	logic [MB-1:0]        mag;

	always_comb begin
		// wrap into one turn; the range needs at most one correction
		if (c_in.z < 0) begin
			zw = c_in.z + fvam_pkg::FULL_TURN;
		end else if (c_in.z >= fvam_pkg::FULL_TURN) begin
			zw = c_in.z - fvam_pkg::FULL_TURN;
		end else begin
			zw = c_in.z;
		end
		// round to 1/128 degree; a full turn reads as zero
		zr  = $unsigned(zw) + fvam_pkg::ANGLE_ROUND;
		ang = zr[8 +: AB];
		if (ang >= fvam_pkg::ANGLE_WRAP) begin
			ang = '0;
		end
		// round to nearest: remainder above the floor root rounds up
		mag = s_in.root + MB'(s_in.rem > RW'(s_in.root));
		if (zero) begin
			res.angle     = '0;
			res.magnitude = '0;
		end else begin
			res.angle     = ang;
			res.magnitude = mag;
		end
	end

endmodule
